@@ rtl/gpioei_pkg.sv @@
// Shared types, codes and constants for the GPIO port with edge interrupts.
package gpioei_pkg;

  localparam int NUM_PINS_DEFAULT = 16;
  localparam int PORT_W           = 16;

  // request type codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_PIN   = 2'd2;

  // port register codes
  localparam logic [2:0] REG_CTL0  = 3'd0;
  localparam logic [2:0] REG_CTL1  = 3'd1;
  localparam logic [2:0] REG_ISTAT = 3'd2;
  localparam logic [2:0] REG_OCTL  = 3'd3;
  localparam logic [2:0] REG_BOP   = 3'd4;
  localparam logic [2:0] REG_BC    = 3'd5;
  localparam logic [2:0] REG_LOCK  = 3'd6;

  // pin event level codes
  localparam logic [1:0] PIN_LOW      = 2'd0;
  localparam logic [1:0] PIN_HIGH     = 2'd1;
  localparam logic [1:0] PIN_RELEASED = 2'd2;
  localparam logic [1:0] PIN_INVALID  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_PORT_NUM = 3'd0;
  localparam logic [2:0] CFG_INT_EN   = 3'd1;
  localparam logic [2:0] CFG_RISE_EN  = 3'd2;
  localparam logic [2:0] CFG_FALL_EN  = 3'd3;
  localparam logic [2:0] CFG_SRC_SEL  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [3:0]  pin_index;
    logic [1:0]  pin_value;
    logic [15:0] pending_now;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pin_levels;
    logic [15:0] pin_push_mask;
    logic [15:0] pending_set;
    logic [6:0]  irq_pulse;
  } resp_t;

  typedef struct packed {
    logic [2:0]  port_number;
    logic [15:0] int_enable_mask;
    logic [15:0] rising_enable_mask;
    logic [15:0] falling_enable_mask;
    logic [63:0] source_select;
  } cfg_t;

  typedef struct packed {
    logic [15:0] status_next;
    logic [15:0] pending_set;
    logic [6:0]  irq_pulse;
  } scan_out_t;

endpackage

@@ rtl/gpioei_scan.sv @@
// Per-pin edge detect and interrupt line mapping for one pin scan.
module gpioei_scan #(
  parameter int NUM_PINS = gpioei_pkg::NUM_PINS_DEFAULT
) (
  input  logic                  scan_en,
  input  logic [15:0]           pin_levels,
  input  logic [15:0]           input_status,
  input  logic [63:0]           ctl_word,
  input  gpioei_pkg::cfg_t      cfg,
  input  logic [15:0]           pending_now,
  output gpioei_pkg::scan_out_t scan_out
);

  localparam logic [15:0] PinMask = 16'((32'd1 << NUM_PINS) - 32'd1);

  logic [15:0] fire;
  logic [15:0] eligible;

  for (genvar i = 0; i < 16; i++) begin : g_pin
    logic input_mode;
    logic sel_hit;
    logic rise;
    logic fall;
    assign input_mode = (ctl_word[4*i +: 2] == 2'b00);
    assign sel_hit    = (cfg.source_select[4*i +: 4] == {1'b0, cfg.port_number});
    assign rise       = !input_status[i] && pin_levels[i];
    assign fall       = input_status[i] && !pin_levels[i];
    assign eligible[i] = input_mode && sel_hit && PinMask[i] &&
                         cfg.int_enable_mask[i] && !pending_now[i];
    assign fire[i]    = eligible[i] &&
                        ((rise && cfg.rising_enable_mask[i]) ||
                         (fall && cfg.falling_enable_mask[i]));
  end

  always_comb begin
    scan_out = '0;
    scan_out.status_next = input_status;
    if (scan_en) begin
      // status tracks the level of every live pin
      scan_out.status_next = (input_status & ~PinMask) | (pin_levels & PinMask);
      scan_out.pending_set = fire;
      scan_out.irq_pulse   = {|fire[15:10], |fire[9:5], fire[4:0]};
    end
  end

endmodule

@@ rtl/gpio_port_with_edge_interrupts_core.sv @@
// Top level of the 16-pin GPIO port with external edge interrupts.
// The result of a request is registered at the same edge that accepts the request.
// Throughput: one request per cycle unless out_ready stalls; the result reg frees as taken.
// Port state is updated at the accept edge, so the next request sees it at once.
// Reset (rst, synchronous): port and config registers cleared, pins low, no result held.
// No clearing pass; the port takes requests the cycle after reset drops.
module gpio_port_with_edge_interrupts_core #(
  parameter int NUM_PINS = gpioei_pkg::NUM_PINS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  gpioei_pkg::req_t  in_req,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output gpioei_pkg::resp_t out_resp,
  // configuration writes
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata
);

  // pins at or above NUM_PINS never leave low
  localparam logic [15:0] PinMask = 16'((32'd1 << NUM_PINS) - 32'd1);

  // configuration
  gpioei_pkg::cfg_t cfg;

  // port state
  logic [31:0] control_low;
  logic [31:0] control_high;
  logic [31:0] output_latch;
  logic [15:0] input_status;
  logic [31:0] bit_operate_copy;
  logic [31:0] bit_clear_copy;
  logic [31:0] lock_word;
  logic [15:0] pin_state;

  logic [31:0] control_low_next;
  logic [31:0] control_high_next;
  logic [31:0] output_latch_next;
  logic [31:0] bit_operate_copy_next;
  logic [31:0] bit_clear_copy_next;
  logic [31:0] lock_word_next;
  logic [15:0] pin_state_next;

  gpioei_pkg::resp_t     resp_next;
  gpioei_pkg::scan_out_t scan_out;

  logic        accept;
  logic        scan_en;
  logic [63:0] ctl_word;
  logic [15:0] pin_bit;
  logic [3:0]  pin_nibble;
  logic        pin_in_range;
  logic        pin_high;
  logic [15:0] set_bits;
  logic [15:0] clr_bits;

  // result register frees when empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // both control words viewed as 16 nibbles, one per pin
  assign ctl_word     = {control_high, control_low};
  assign pin_bit      = 16'd1 << in_req.pin_index;
  assign pin_nibble   = ctl_word[{in_req.pin_index, 2'b00} +: 4];
  assign pin_in_range = ({1'b0, in_req.pin_index} < 5'(NUM_PINS));

  // BOP: low half sets, high half clears, set wins; BC: low half clears
  always_comb begin
    set_bits = '0;
    clr_bits = '0;
    if (in_req.reg_index == gpioei_pkg::REG_BOP) begin
      set_bits = in_req.write_data[15:0];
      clr_bits = in_req.write_data[31:16];
    end else if (in_req.reg_index == gpioei_pkg::REG_BC) begin
      clr_bits = in_req.write_data[15:0];
    end
  end

  // released pin floats high only on pull-up with latch set
  always_comb begin
    if (in_req.pin_value == gpioei_pkg::PIN_RELEASED) begin
      pin_high = pin_nibble[3] && output_latch[{1'b0, in_req.pin_index}];
    end else begin
      pin_high = (in_req.pin_value == gpioei_pkg::PIN_HIGH);
    end
  end

  // request decode and next port state
  always_comb begin
    control_low_next      = control_low;
    control_high_next     = control_high;
    output_latch_next     = output_latch;
    bit_operate_copy_next = bit_operate_copy;
    bit_clear_copy_next   = bit_clear_copy;
    lock_word_next        = lock_word;
    pin_state_next        = pin_state;
    resp_next             = '0;
    scan_en               = 1'b0;

    case (in_req.req_type)
      gpioei_pkg::REQ_READ: begin
        case (in_req.reg_index)
          gpioei_pkg::REG_CTL0:  resp_next.read_data = control_low;
          gpioei_pkg::REG_CTL1:  resp_next.read_data = control_high;
          gpioei_pkg::REG_ISTAT: resp_next.read_data = {16'd0, input_status};
          gpioei_pkg::REG_OCTL:  resp_next.read_data = output_latch;
          gpioei_pkg::REG_BOP:   resp_next.read_data = bit_operate_copy;
          gpioei_pkg::REG_BC:    resp_next.read_data = bit_clear_copy;
          gpioei_pkg::REG_LOCK:  resp_next.read_data = lock_word;
          default:               resp_next.read_data = '0;
        endcase
      end
      gpioei_pkg::REQ_WRITE: begin
        case (in_req.reg_index)
          gpioei_pkg::REG_CTL0: control_low_next  = in_req.write_data;
          gpioei_pkg::REG_CTL1: control_high_next = in_req.write_data;
          gpioei_pkg::REG_OCTL: begin
            output_latch_next       = in_req.write_data;
            pin_state_next          = in_req.write_data[15:0] & PinMask;
            resp_next.pin_push_mask = PinMask;
          end
          gpioei_pkg::REG_BOP: begin
            output_latch_next = (output_latch & ~{16'd0, clr_bits}) | {16'd0, set_bits};
            pin_state_next    = ((pin_state & ~clr_bits) | set_bits) & PinMask;
            resp_next.pin_push_mask = (set_bits | clr_bits) & PinMask;
            bit_operate_copy_next   = in_req.write_data;
          end
          gpioei_pkg::REG_BC: begin
            output_latch_next       = output_latch & ~{16'd0, clr_bits};
            pin_state_next          = pin_state & ~clr_bits;
            resp_next.pin_push_mask = clr_bits & PinMask;
            bit_clear_copy_next     = in_req.write_data;
          end
          gpioei_pkg::REG_LOCK: lock_word_next = in_req.write_data;
          default: ;  // istat is read-only, index seven unused
        endcase
      end
      gpioei_pkg::REQ_PIN: begin
        if (pin_in_range && in_req.pin_value != gpioei_pkg::PIN_INVALID) begin
          pin_state_next = pin_high ? (pin_state | pin_bit) : (pin_state & ~pin_bit);
          // only a level change scans the port
          scan_en = (pin_state_next != pin_state);
        end
      end
      default: ;
    endcase

    resp_next.pin_levels  = pin_state_next;
    resp_next.pending_set = scan_out.pending_set;
    resp_next.irq_pulse   = scan_out.irq_pulse;
  end

  gpioei_scan #(
    .NUM_PINS (NUM_PINS)
  ) u_scan (
    .scan_en      (scan_en),
    .pin_levels   (pin_state_next),
    .input_status (input_status),
    .ctl_word     (ctl_word),
    .cfg          (cfg),
    .pending_now  (in_req.pending_now),
    .scan_out     (scan_out)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gpioei_pkg::CFG_PORT_NUM: cfg.port_number         <= cfg_wdata[2:0];
        gpioei_pkg::CFG_INT_EN:   cfg.int_enable_mask     <= cfg_wdata[15:0];
        gpioei_pkg::CFG_RISE_EN:  cfg.rising_enable_mask  <= cfg_wdata[15:0];
        gpioei_pkg::CFG_FALL_EN:  cfg.falling_enable_mask <= cfg_wdata[15:0];
        gpioei_pkg::CFG_SRC_SEL:  cfg.source_select       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // port state, updated as each request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      control_low      <= '0;
      control_high     <= '0;
      output_latch     <= '0;
      input_status     <= '0;
      bit_operate_copy <= '0;
      bit_clear_copy   <= '0;
      lock_word        <= '0;
      pin_state        <= '0;
    end else if (accept) begin
      control_low      <= control_low_next;
      control_high     <= control_high_next;
      output_latch     <= output_latch_next;
      input_status     <= scan_out.status_next;
      bit_operate_copy <= bit_operate_copy_next;
      bit_clear_copy   <= bit_clear_copy_next;
      lock_word        <= lock_word_next;
      pin_state        <= pin_state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_resp <= resp_next;
    end
  end

endmodule
